[sv/kvt_pkg.sv]
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int DEF_CAPACITY   = 32;
	localparam int DEF_KEY_BITS   = 16;
	localparam int DEF_VALUE_BITS = 32;

	localparam int OPCODE_W = 2;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ERASE  = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_COUNT  = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DUP  = 2'd2,
		ST_MISS = 2'd3
	} status_t;

	// Walking query token and its running key-hit flag.
	typedef struct packed {
		logic tok;
		logic found;
	} cell_ctl_t;

endpackage

[sv/kvt_cell.sv]
`timescale 1ns / 1ps

module kvt_cell #(
	parameter int IDX        = 0,
	parameter int KEY_BITS   = 16,
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kvt_pkg::opcode_t      q_op,
	input  logic [KEY_BITS-1:0]   q_key,
	input  logic [VALUE_BITS-1:0] q_val,
	input  logic [CNT_W-1:0]      count,
	input  logic                  ins_en,
	input  kvt_pkg::cell_ctl_t    ctl_in,
	input  logic [VALUE_BITS-1:0] vacc_in,
	input  logic [CNT_W-1:0]      cacc_in,
	input  logic [KEY_BITS-1:0]   nxt_key,
	input  logic [VALUE_BITS-1:0] nxt_val,
	output kvt_pkg::cell_ctl_t    ctl_out,
	output logic [VALUE_BITS-1:0] vacc_out,
	output logic [CNT_W-1:0]      cacc_out,
	output logic [KEY_BITS-1:0]   key_out,
	output logic [VALUE_BITS-1:0] val_out
);
	import kvt_pkg::*;

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	cell_ctl_t             ctl_q;
	logic [VALUE_BITS-1:0] vacc_q;
	logic [CNT_W-1:0]      cacc_q;
	logic                  occupied;
	logic                  key_hit;
	logic                  val_hit;
	logic                  shift;
	logic                  wr;

	assign occupied = CNT_W'(IDX) < count;
	assign key_hit  = occupied && (key_q == q_key);
	assign val_hit  = occupied && (val_q == q_val);
	// Erase compacts: every cell at or past the hit takes its upper neighbor.
	assign shift    = ctl_in.tok && (q_op == OP_ERASE) && (ctl_in.found || key_hit);
	assign wr       = ins_en && (count == CNT_W'(IDX));

	always_ff @(posedge clk) begin
		if (wr) begin
			key_q <= q_key;
			val_q <= q_val;
		end else if (shift) begin
			key_q <= nxt_key;
			val_q <= nxt_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.tok   <= ctl_in.tok;
			ctl_q.found <= ctl_in.found || key_hit;
		end
	end

	always_ff @(posedge clk) begin
		vacc_q <= key_hit ? (vacc_in | val_q) : vacc_in;
		cacc_q <= cacc_in + CNT_W'(val_hit);
	end

	assign ctl_out  = ctl_q;
	assign vacc_out = vacc_q;
	assign cacc_out = cacc_q;
	assign key_out  = key_q;
	assign val_out  = val_q;

endmodule

[sv/keyed_value_table.sv]
`timescale 1ns / 1ps

// Key-value table of up to CAPACITY_ENTRIES unique keys, built as a row of
// cells that each hold one key and one value. An item carries an opcode
// (insert, erase, lookup, count) with a key and a value; a query token walks
// the row one cell per cycle, collecting the key hit, the stored value and
// the count of value matches. Insert writes the next free cell once the walk
// has ruled out a duplicate; erase closes the hole by shifting the upper
// cells down one place as the token passes them. Every result carries the
// occupancy after the operation. A new item is accepted only in the idle
// state, after the token has left the row and the previous result has moved
// from the result register into the output register; the result may wait
// there while the next item is taken.
module keyed_value_table #(
	parameter int CAPACITY_ENTRIES = kvt_pkg::DEF_CAPACITY,
	parameter int KEY_BITS         = kvt_pkg::DEF_KEY_BITS,
	parameter int VALUE_BITS       = kvt_pkg::DEF_VALUE_BITS,
	localparam int CNT_W       = $clog2(CAPACITY_ENTRIES + 1),
	localparam int IN_W        = kvt_pkg::OPCODE_W + KEY_BITS + VALUE_BITS,
	localparam int OUT_W       = kvt_pkg::STATUS_W + 1 + VALUE_BITS + 2 * CNT_W,
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// opcode, key, value (from bit 0 up), zero padded
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// status, found, value_out, match_count, occupancy (from bit 0 up),
	// zero padded
	output logic [OUT_TDATA_W-1:0] m_tdata
);
	import kvt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t                 state_q;
	logic                   start_q;
	opcode_t                op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [CNT_W-1:0]       count_q;
	logic [OUT_TDATA_W-1:0] res_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	cell_ctl_t              ctl_s   [0:CAPACITY_ENTRIES];
	logic [VALUE_BITS-1:0]  vacc    [0:CAPACITY_ENTRIES];
	logic [CNT_W-1:0]       cacc    [0:CAPACITY_ENTRIES];
	logic [KEY_BITS-1:0]    ckey    [0:CAPACITY_ENTRIES-1];
	logic [VALUE_BITS-1:0]  cval    [0:CAPACITY_ENTRIES-1];
	logic [CAPACITY_ENTRIES:0] tok_vec;

	logic                   accept;
	logic                   tok_last;
	logic                   found_last;
	logic                   full;
	logic                   ins_commit;
	logic                   ers_commit;
	logic [CNT_W-1:0]       count_nxt;
	status_t                status_d;
	logic                   found_d;
	logic [VALUE_BITS-1:0]  vout_d;
	logic [CNT_W-1:0]       matches_d;
	logic                   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Hold the query for the whole walk; launch the token in the cycle after acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(s_tdata[OPCODE_W-1:0]);
			key_q <= s_tdata[OPCODE_W +: KEY_BITS];
			val_q <= s_tdata[OPCODE_W + KEY_BITS +: VALUE_BITS];
		end
	end

	assign ctl_s[0].tok   = start_q;
	assign ctl_s[0].found = 1'b0;
	assign vacc[0]        = '0;
	assign cacc[0]        = '0;

	// Row of cells; the top cell refills from itself on a shift.
	for (genvar i = 0; i < CAPACITY_ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0]   up_key;
		logic [VALUE_BITS-1:0] up_val;

		if (i == CAPACITY_ENTRIES - 1) begin : g_top
			assign up_key = ckey[i];
			assign up_val = cval[i];
		end else begin : g_mid
			assign up_key = ckey[i+1];
			assign up_val = cval[i+1];
		end

		kvt_cell #(
			.IDX        (i),
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.q_op     (op_q),
			.q_key    (key_q),
			.q_val    (val_q),
			.count    (count_q),
			.ins_en   (ins_commit),
			.ctl_in   (ctl_s[i]),
			.vacc_in  (vacc[i]),
			.cacc_in  (cacc[i]),
			.nxt_key  (up_key),
			.nxt_val  (up_val),
			.ctl_out  (ctl_s[i+1]),
			.vacc_out (vacc[i+1]),
			.cacc_out (cacc[i+1]),
			.key_out  (ckey[i]),
			.val_out  (cval[i])
		);
	end

	for (genvar i = 0; i <= CAPACITY_ENTRIES; i++) begin : g_tok
		assign tok_vec[i] = ctl_s[i].tok;
	end

	assign tok_last   = (state_q == S_WALK) && ctl_s[CAPACITY_ENTRIES].tok;
	assign found_last = ctl_s[CAPACITY_ENTRIES].found;
	assign full       = (count_q >= CNT_W'(CAPACITY_ENTRIES));

	// Inserts and occupancy changes land when the token leaves the last cell.
	assign ins_commit = tok_last && (op_q == OP_INSERT) && !full && !found_last;
	assign ers_commit = tok_last && (op_q == OP_ERASE) && found_last;

	always_comb begin
		count_nxt = count_q;
		if (ins_commit) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (ers_commit) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Result fields; full wins over duplicate on insert.
	always_comb begin
		status_d  = ST_OK;
		found_d   = 1'b0;
		vout_d    = '0;
		matches_d = '0;
		case (op_q)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else if (found_last) begin
					status_d = ST_DUP;
				end
			end
			OP_ERASE: begin
				found_d  = found_last;
				status_d = found_last ? ST_OK : ST_MISS;
			end
			OP_LOOKUP: begin
				found_d  = found_last;
				status_d = found_last ? ST_OK : ST_MISS;
				vout_d   = found_last ? vacc[CAPACITY_ENTRIES] : '0;
			end
			OP_COUNT: begin
				matches_d = cacc[CAPACITY_ENTRIES];
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
			count_q <= '0;
		end else begin
			start_q <= accept;
			count_q <= count_nxt;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (tok_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Pack the result as it leaves the row.
	always_ff @(posedge clk) begin
		if (tok_last) begin
			res_q <= OUT_TDATA_W'({count_nxt, matches_d, vout_d, found_d, status_d});
		end
	end

	// Output register: hold the item until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY_ENTRIES))
		else $error("occupancy above capacity");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("more than one query token in the row");

	a_token_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[CAPACITY_ENTRIES].tok |-> state_q == S_WALK)
		else $error("token left the row outside a walk");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ins_commit |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow occupancy");

	a_erase_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ers_commit |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("erase did not shrink occupancy");
`endif

endmodule
